FILE: rtl/core/fyp_pkg.sv
`default_nettype none

package fyp_pkg;

  // Table geometry follows from the fixed field widths.
  localparam int TABLE_DEPTH = 1024;
  localparam int IDX_W       = 10;
  localparam int CNT_W       = 11;
  localparam int WORD_W      = 64;
  localparam int STEP_CNT_W  = $clog2(WORD_W);

  localparam int CMD_W = 2;
  localparam logic [CMD_W-1:0] CMD_RESTART = 2'd0;
  localparam logic [CMD_W-1:0] CMD_STEP    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ    = 2'd2;

  typedef logic [IDX_W-1:0] idx_t;

  // One table word: the written flag beside the stored index.
  typedef struct packed {
    logic written;
    idx_t value;
  } entry_t;

endpackage

`default_nettype wire

FILE: rtl/core/fyp_modunit.sv
`default_nettype none

// Bit-serial restoring remainder: one dividend bit per cycle.
module fyp_modunit import fyp_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [WORD_W-1:0] dividend,
  input  wire logic [CNT_W-1:0]  divisor,
  output logic                   done,
  output idx_t                   rem
);

  logic                  busy_r;
  logic                  done_r;
  logic [STEP_CNT_W-1:0] cnt_r;
  logic [WORD_W-1:0]     sh_r;
  logic [CNT_W-1:0]      rem_r;
  logic [CNT_W-1:0]      div_r;

  logic [CNT_W:0]   trial;
  logic [CNT_W:0]   diff;
  logic [CNT_W-1:0] rem_step;

  always_comb begin
    trial    = {rem_r, sh_r[WORD_W-1]};
    diff     = trial - {1'b0, div_r};
    rem_step = (trial >= {1'b0, div_r}) ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + STEP_CNT_W'(1);
        if (cnt_r == STEP_CNT_W'(WORD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh_r  <= dividend;
      rem_r <= '0;
      div_r <= divisor;
    end else if (busy_r) begin
      sh_r  <= {sh_r[WORD_W-2:0], 1'b0};
      rem_r <= rem_step;
    end
  end

  // The divisor never exceeds the table depth, so the remainder fits an index.
  assign done = done_r;
  assign rem  = rem_r[IDX_W-1:0];

endmodule

`default_nettype wire

FILE: rtl/core/fisher_yates_permutation_engine.sv
`default_nettype none

// Fisher-Yates permutation engine over a 1024-entry table.
// Input words carry a command in in_tuser (0 restart, 1 shuffle step, 2 read)
// and the random word and read index in in_tdata. Every input word yields one
// output word holding the chosen swap partner, the read entry or zero, plus a
// flag that is set once the shuffle position has reached zero.
// perm_count is written on the cfg channel (always ready); the user must write
// it only while the block is idle, which the block does not enforce. It takes
// effect at the next restart. In a shuffle step the bit-serial remainder unit
// computes word mod (position+1), then state S_READ fetches both entries and
// states S_WRA and S_WRB write them back through the single table write port.
// A restart sweeps the whole table to clear the written flags. The same sweep
// runs after reset, during which in_tready stays low. One word is processed at
// a time; a finished word waits in the output register, and a new input is
// taken while it waits. If the receiver stalls with a word still held, the
// next result waits until it is taken.
module fisher_yates_permutation_engine import fyp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input channel.
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [79:0] in_tdata,   // random_word[63:0], read_index[73:64], zero fill
  input  wire logic [1:0]  in_tuser,   // cmd[1:0]
  // Result channel.
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // result_value[9:0], done_res[10], zero fill
  // Configuration channel: perm_count.
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [10:0] cfg_data
);

  localparam logic [2:0] S_INIT  = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_CLEAR = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_READ  = 3'd4;
  localparam logic [2:0] S_WRA   = 3'd5;
  localparam logic [2:0] S_WRB   = 3'd6;
  localparam logic [2:0] S_FIN   = 3'd7;

  // Control registers.
  logic [2:0]       state_r,     state_nxt;
  logic [CNT_W-1:0] perm_cnt_r;
  idx_t             pos_r,       pos_nxt;
  idx_t             clr_r,       clr_nxt;
  logic             out_valid_r, out_valid_nxt;

  // Payload registers.
  logic [CMD_W-1:0] cmd_r,       cmd_nxt;
  idx_t             ridx_r,      ridx_nxt;
  idx_t             j_r,         j_nxt;
  idx_t             res_r,       res_nxt;
  idx_t             out_value_r, out_value_nxt;
  logic             out_done_r,  out_done_nxt;

  // Table with one write port and two registered read ports.
  entry_t mem [TABLE_DEPTH];
  entry_t rd_a_r;
  entry_t rd_b_r;
  logic   mem_we;
  idx_t   mem_waddr;
  entry_t mem_wdata;
  logic   rd_en;
  idx_t   addr_a;

  logic             in_acc;
  logic [CMD_W-1:0] in_cmd;
  logic [WORD_W-1:0] in_word;
  idx_t             in_ridx;
  logic [CNT_W-1:0] n_clamp;
  idx_t             pos_restart;
  idx_t             entry_a;
  idx_t             entry_b;

  logic div_start;
  logic div_done;
  idx_t div_rem;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign in_cmd    = in_tuser;
  assign in_word   = in_tdata[63:0];
  assign in_ridx   = in_tdata[73:64];
  assign cfg_ready = 1'b1;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_done_r, out_value_r};

  // A count of zero behaves as one; a count above the depth saturates.
  always_comb begin
    if (perm_cnt_r == '0) begin
      n_clamp = CNT_W'(1);
    end else if (perm_cnt_r > CNT_W'(TABLE_DEPTH)) begin
      n_clamp = CNT_W'(TABLE_DEPTH);
    end else begin
      n_clamp = perm_cnt_r;
    end
  end

  assign pos_restart = IDX_W'(n_clamp - CNT_W'(1));

  // Port A reads the current position for a step and the requested index for
  // a read. An entry that was never written since the last sweep reads as its
  // own index.
  assign addr_a  = (cmd_r == CMD_READ) ? ridx_r : pos_r;
  assign entry_a = rd_a_r.written ? rd_a_r.value : addr_a;
  assign entry_b = rd_b_r.written ? rd_b_r.value : j_r;

  fyp_modunit u_modunit (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (in_word),
    .divisor  ({1'b0, pos_r} + CNT_W'(1)),
    .done     (div_done),
    .rem      (div_rem)
  );

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    clr_nxt       = clr_r;
    cmd_nxt       = cmd_r;
    ridx_nxt      = ridx_r;
    j_nxt         = j_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_value_nxt = out_value_r;
    out_done_nxt  = out_done_r;
    mem_we        = 1'b0;
    mem_waddr     = clr_r;
    mem_wdata     = '0;
    div_start     = 1'b0;
    rd_en         = 1'b0;

    unique case (state_r)
      S_INIT: begin
        // Power-up sweep: mark every entry as not written.
        mem_we  = 1'b1;
        clr_nxt = clr_r + IDX_W'(1);
        if (clr_r == IDX_W'(TABLE_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          cmd_nxt  = in_cmd;
          ridx_nxt = in_ridx;
          res_nxt  = '0;
          case (in_cmd)
            CMD_RESTART: begin
              pos_nxt   = pos_restart;
              clr_nxt   = '0;
              state_nxt = S_CLEAR;
            end
            CMD_STEP: begin
              if (pos_r != '0) begin
                div_start = 1'b1;
                state_nxt = S_DIV;
              end else begin
                state_nxt = S_FIN;
              end
            end
            CMD_READ: begin
              state_nxt = S_READ;
            end
            default: begin
              state_nxt = S_FIN;
            end
          endcase
        end
      end
      S_CLEAR: begin
        mem_we  = 1'b1;
        clr_nxt = clr_r + IDX_W'(1);
        if (clr_r == IDX_W'(TABLE_DEPTH - 1)) begin
          state_nxt = S_FIN;
        end
      end
      S_DIV: begin
        if (div_done) begin
          j_nxt     = div_rem;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        rd_en     = 1'b1;
        state_nxt = (cmd_r == CMD_STEP) ? S_WRA : S_FIN;
      end
      S_WRA: begin
        mem_we    = 1'b1;
        mem_waddr = pos_r;
        mem_wdata = '{written: 1'b1, value: entry_b};
        state_nxt = S_WRB;
      end
      S_WRB: begin
        // When the partner equals the position both writes carry the same
        // value, so the entry stays unchanged.
        mem_we    = 1'b1;
        mem_waddr = j_r;
        mem_wdata = '{written: 1'b1, value: entry_a};
        pos_nxt   = pos_r - IDX_W'(1);
        res_nxt   = j_r;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = (cmd_r == CMD_READ) ? entry_a : res_r;
          out_done_nxt  = (pos_r == '0);
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      perm_cnt_r  <= CNT_W'(1024);
      pos_r       <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        perm_cnt_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    ridx_r      <= ridx_nxt;
    j_r         <= j_nxt;
    res_r       <= res_nxt;
    out_value_r <= out_value_nxt;
    out_done_r  <= out_done_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_a_r <= mem[addr_a];
      rd_b_r <= mem[j_r];
    end
  end

endmodule

`default_nettype wire
